[hw/rtl/button_click_hold_detector_macros.svh]
// Assertion macros shared by the button click and hold detector.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define BCD_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button_click_hold_detector check failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define BCD_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button_click_hold_detector check failed");

`endif

[hw/rtl/bcd_pkg.sv]
// Types, constants and helper functions of the button click and hold detector.
`timescale 1ns / 1ps

package bcd_pkg;

  // Width of the internal click counter; it saturates at all ones.
  localparam int CLICK_COUNT_BITS = 8;

  localparam int TIME_BITS   = 32;
  localparam int TOTAL_BITS  = 8;
  localparam int EVENT_BITS  = 3;
  localparam int EVENT_COUNT = 6;
  localparam int ENABLE_BITS = EVENT_COUNT;

  // Event codes, also the bit positions in an event mask.
  localparam logic [EVENT_BITS-1:0] EV_DOWN         = 3'd0;
  localparam logic [EVENT_BITS-1:0] EV_UP           = 3'd1;
  localparam logic [EVENT_BITS-1:0] EV_HOLD         = 3'd2;
  localparam logic [EVENT_BITS-1:0] EV_HOLD_RELEASE = 3'd3;
  localparam logic [EVENT_BITS-1:0] EV_CLICKS       = 3'd4;
  localparam logic [EVENT_BITS-1:0] EV_SWITCH       = 3'd5;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HOLD_THRESHOLD = 2'd0,
    REG_CLICK_GAP      = 2'd1,
    REG_EVENT_ENABLE   = 2'd2
  } cfg_reg_e;

  localparam logic [TIME_BITS-1:0]   HOLD_THRESHOLD_RESET = 32'd1000;
  localparam logic [TIME_BITS-1:0]   CLICK_GAP_RESET      = 32'd300;
  localparam logic [ENABLE_BITS-1:0] EVENT_ENABLE_RESET   = 6'h3F;

  // Event queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                 pressed;
    logic [TIME_BITS-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [EVENT_BITS-1:0] event_res;
    logic [TOTAL_BITS-1:0] click_total;
    logic                  switch_on;
    logic                  last;
  } result_t;

  // All events caused by one sample, already filtered by the enables.
  typedef struct packed {
    logic [EVENT_COUNT-1:0] mask;
    logic [TOTAL_BITS-1:0]  click_total;
    logic                   switch_on;
  } evt_rec_t;

  typedef struct packed {
    logic     valid;
    evt_rec_t rec;
  } push_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [COUNT_BITS-1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic     valid;
    evt_rec_t rec;
  } queue_head_t;

  // Reported click total, clamped to what the result field can carry.
  function automatic logic [TOTAL_BITS-1:0] clamp_total(
    input logic [CLICK_COUNT_BITS-1:0] cnt
  );
    logic [31:0] wide;
    wide = 32'(cnt);
    if (wide > 32'd255) begin
      return 8'hFF;
    end
    return wide[TOTAL_BITS-1:0];
  endfunction

endpackage

[hw/rtl/button_click_hold_detector.sv]
// Top level of the button click and hold detector.
`timescale 1ns / 1ps

// Button click and hold detector. Each sample transaction carries the
// button level and a free-running millisecond timestamp; the block turns
// the sample stream into down, hold, up, hold_release, clicks and switch
// result transactions, with last marking the final result of a sample.
// The front part classifies a sample in the cycle it is accepted and
// updates the button state; a two-entry event queue separates it from the
// back part, which sends the events of one sample one per cycle, while the
// result channel does not stall, through a registered output. A sample is
// taken every cycle while the queue has room, so the sustained rate is set
// by the result channel: a sample causes zero to three results, and a
// sample that causes no result takes no place in the queue. Results of a
// sample pass through the queue, the back part's record register and the
// output register. Configuration transactions are always accepted and take
// effect on the next sample; writes to an index beyond the last register are ignored.
module button_click_hold_detector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  bcd_pkg::sample_t                    sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output bcd_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bcd_pkg::TIME_BITS-1:0]       cfg_data
);

  `include "button_click_hold_detector_macros.svh"

  bcd_pkg::push_t         push;
  bcd_pkg::queue_head_t   head;
  bcd_pkg::queue_status_t qstat;
  logic                   pop;

  // Front: accepts samples, tracks press, hold and click state.
  bcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .qstat        (qstat),
    .push         (push)
  );

  // Queue: holds event records of samples that wait for the back part.
  bcd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Back: serializes each record into result transactions.
  bcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // The front never pushes into a full queue, so no record is lost.
  `BCD_CHECK(a_no_push_when_full, qstat.full, !push.valid)
  // A pushed record is visible in the queue in the next cycle.
  `BCD_CHECK_NEXT(a_push_lands, push.valid, !qstat.empty)
  // Only a clicks result carries a click total.
  `BCD_CHECK(a_total_only_on_clicks,
    result_valid && (result.event_res != bcd_pkg::EV_CLICKS), result.click_total == '0)
  // Only event codes that exist leave the block.
  `BCD_CHECK(a_event_code_range, result_valid, result.event_res <= bcd_pkg::EV_SWITCH)

endmodule

[hw/rtl/bcd_front.sv]
// Front part: configuration registers, button state tracking and event classification.
`timescale 1ns / 1ps

module bcd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  bcd_pkg::sample_t                    sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bcd_pkg::TIME_BITS-1:0]       cfg_data,
  input  bcd_pkg::queue_status_t              qstat,
  output bcd_pkg::push_t                      push
);

  logic [bcd_pkg::TIME_BITS-1:0]        hold_threshold;
  logic [bcd_pkg::TIME_BITS-1:0]        click_gap;
  logic [bcd_pkg::ENABLE_BITS-1:0]      event_enable;

  logic                                 prev_pressed;
  logic [bcd_pkg::TIME_BITS-1:0]        hold_start;
  logic [bcd_pkg::TIME_BITS-1:0]        last_click_time;
  logic [bcd_pkg::CLICK_COUNT_BITS-1:0] click_counter;
  logic                                 clicks_pending;
  logic                                 holding;
  logic                                 toggle_on;

  logic [bcd_pkg::TIME_BITS-1:0]        hold_start_next;
  logic [bcd_pkg::TIME_BITS-1:0]        last_click_time_next;
  logic [bcd_pkg::CLICK_COUNT_BITS-1:0] click_counter_next;
  logic                                 clicks_pending_next;
  logic                                 holding_next;
  logic                                 toggle_on_next;

  logic [bcd_pkg::CLICK_COUNT_BITS-1:0] cnt_mid;
  logic                                 pending_mid;
  logic [bcd_pkg::TIME_BITS-1:0]        last_mid;
  logic [bcd_pkg::TIME_BITS-1:0]        press_age;
  logic [bcd_pkg::TIME_BITS-1:0]        quiet_age;
  logic [bcd_pkg::EVENT_COUNT-1:0]      raw_mask;
  logic                                 accept;

  assign sample_ready = !qstat.full;
  assign cfg_ready    = 1'b1;
  assign accept       = sample_valid && sample_ready;

  assign press_age = sample.now_ms - hold_start;

  always_comb begin
    hold_start_next      = hold_start;
    holding_next         = holding;
    toggle_on_next       = toggle_on;
    cnt_mid              = click_counter;
    pending_mid          = clicks_pending;
    last_mid             = last_click_time;
    raw_mask             = '0;

    // Press and release part.
    if (sample.pressed) begin
      if (prev_pressed) begin
        if (press_age >= hold_threshold && !holding) begin
          holding_next             = 1'b1;
          raw_mask[bcd_pkg::EV_HOLD] = 1'b1;
        end
      end else begin
        hold_start_next            = sample.now_ms;
        raw_mask[bcd_pkg::EV_DOWN] = 1'b1;
      end
    end else begin
      hold_start_next = sample.now_ms;
      if (prev_pressed) begin
        raw_mask[bcd_pkg::EV_UP] = 1'b1;
        if (holding) begin
          raw_mask[bcd_pkg::EV_HOLD_RELEASE] = 1'b1;
          holding_next = 1'b0;
          pending_mid  = 1'b0;
          cnt_mid      = '0;
        end else begin
          last_mid    = sample.now_ms;
          pending_mid = 1'b1;
          if (click_counter != '1) begin
            cnt_mid = click_counter + 1'b1;
          end
        end
      end
    end

    // Click report, seen on the state after the press part.
    quiet_age            = sample.now_ms - last_mid;
    click_counter_next   = cnt_mid;
    clicks_pending_next  = pending_mid;
    last_click_time_next = last_mid;
    if (pending_mid && quiet_age >= click_gap) begin
      raw_mask[bcd_pkg::EV_CLICKS] = 1'b1;
      if (cnt_mid == bcd_pkg::CLICK_COUNT_BITS'(1)) begin
        toggle_on_next               = !toggle_on;
        raw_mask[bcd_pkg::EV_SWITCH] = 1'b1;
      end
      click_counter_next   = '0;
      clicks_pending_next  = 1'b0;
      last_click_time_next = sample.now_ms;
    end
  end

  always_comb begin
    push.rec.mask        = raw_mask & event_enable;
    push.rec.click_total = bcd_pkg::clamp_total(cnt_mid);
    push.rec.switch_on   = toggle_on_next;
    push.valid           = accept && (push.rec.mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_threshold  <= bcd_pkg::HOLD_THRESHOLD_RESET;
      click_gap       <= bcd_pkg::CLICK_GAP_RESET;
      event_enable    <= bcd_pkg::EVENT_ENABLE_RESET;
      prev_pressed    <= 1'b0;
      hold_start      <= '0;
      last_click_time <= '0;
      click_counter   <= '0;
      clicks_pending  <= 1'b0;
      holding         <= 1'b0;
      toggle_on       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bcd_pkg::REG_HOLD_THRESHOLD: hold_threshold <= cfg_data;
          bcd_pkg::REG_CLICK_GAP:      click_gap      <= cfg_data;
          bcd_pkg::REG_EVENT_ENABLE:
            event_enable <= cfg_data[bcd_pkg::ENABLE_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_pressed    <= sample.pressed;
        hold_start      <= hold_start_next;
        last_click_time <= last_click_time_next;
        click_counter   <= click_counter_next;
        clicks_pending  <= clicks_pending_next;
        holding         <= holding_next;
        toggle_on       <= toggle_on_next;
      end
    end
  end

endmodule

[hw/rtl/bcd_queue.sv]
// Short event queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module bcd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  bcd_pkg::push_t         push,
  input  logic                   pop,
  output bcd_pkg::queue_head_t   head,
  output bcd_pkg::queue_status_t qstat
);

  bcd_pkg::evt_rec_t             entries [bcd_pkg::QUEUE_DEPTH];
  logic [bcd_pkg::PTR_BITS-1:0]   wr_ptr;
  logic [bcd_pkg::PTR_BITS-1:0]   rd_ptr;
  logic [bcd_pkg::COUNT_BITS-1:0] count;
  logic                           do_push;
  logic                           do_pop;

  assign qstat.count = count;
  assign qstat.full  = (count == bcd_pkg::COUNT_BITS'(bcd_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  assign do_push = push.valid && !qstat.full;
  assign do_pop  = pop && !qstat.empty;

  assign head.valid = !qstat.empty;
  assign head.rec   = entries[rd_ptr];

  function automatic logic [bcd_pkg::PTR_BITS-1:0] ptr_inc(
    input logic [bcd_pkg::PTR_BITS-1:0] p
  );
    if (p == bcd_pkg::PTR_BITS'(bcd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/bcd_back.sv]
// Back part: serializes records into registered results, one per cycle unless stalled.
`timescale 1ns / 1ps

module bcd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bcd_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_ready,
  output bcd_pkg::result_t     result
);

  logic [bcd_pkg::EVENT_COUNT-1:0] cur_mask;
  logic [bcd_pkg::TOTAL_BITS-1:0]  cur_total;
  logic                            cur_switch;

  logic [bcd_pkg::EVENT_COUNT-1:0] mask_rest;
  logic [bcd_pkg::EVENT_COUNT-1:0] mask_after;
  logic [bcd_pkg::EVENT_BITS-1:0]  sel_code;
  logic                            slot_free;
  logic                            advance;

  // Events leave in ascending code order, which is the required order.
  always_comb begin
    sel_code = bcd_pkg::EV_DOWN;
    for (int i = bcd_pkg::EVENT_COUNT - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        sel_code = bcd_pkg::EVENT_BITS'(i);
      end
    end
  end

  assign mask_rest  = cur_mask & (cur_mask - 1'b1);
  assign slot_free  = !result_valid || result_ready;
  assign advance    = (cur_mask != '0) && slot_free;
  assign mask_after = advance ? mask_rest : cur_mask;
  assign pop        = head.valid && (mask_after == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask     <= '0;
      result_valid <= 1'b0;
    end else begin
      cur_mask <= pop ? head.rec.mask : mask_after;
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_total  <= head.rec.click_total;
      cur_switch <= head.rec.switch_on;
    end
    if (advance) begin
      result.event_res   <= sel_code;
      result.click_total <= (sel_code == bcd_pkg::EV_CLICKS) ? cur_total : '0;
      result.switch_on   <= (sel_code == bcd_pkg::EV_SWITCH) ? cur_switch : 1'b0;
      result.last        <= (mask_rest == '0);
    end
  end

endmodule
